// File: hw/rtl/rhp_pkg.sv
// Shared constants and types for the reference-counted handle pool.
package rhp_pkg;

  localparam int HANDLES    = 1024;
  localparam int COUNT_BITS = 16;
  localparam int TAG_BITS   = 32;

  localparam int ADDR_BITS  = $clog2(HANDLES);
  localparam int IDX_W      = 11;
  localparam int TAG_W      = 32;
  localparam int CNT_W      = 16;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 64;

  localparam logic [IDX_W-1:0] NO_HANDLE = IDX_W'(HANDLES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ASSIGN = 2'd0,
    OP_ADD    = 2'd1,
    OP_DROP   = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_IGNORED   = 2'd2,
    STS_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT = 3'b001,
    S_IDLE = 3'b010,
    S_EXEC = 3'b100
  } state_t;

endpackage

// File: hw/rtl/refcounted_handle_pool.sv
// Top level: handle pool with free list and per-slot reference counts.
//
// Input channel in_*: one operation per item. in_tuser carries the opcode
// (assign, add reference, drop reference, lookup); in_tdata carries the
// handle index and the object tag. Result channel out_*: one result item
// per operation with status in out_tuser and index, tag, count and freed
// flag in out_tdata.
// Each operation is a read of the slot tables (registered when the item is
// accepted) followed by a modify and write-back in the EXEC state, and the
// block takes no new item until that write-back is done. The read-modify-
// write loop through the slot memories keeps items from overlapping.
// After reset a clearing pass over all HANDLES slots (1024) zeroes the counts
// and rebuilds the free-list links; in_tready stays low during it.
// Results go to an output register. While a result waits, the next item is
// still accepted and read; its write-back then waits until the output
// register is taken, and in_tready stays low meanwhile.
module refcounted_handle_pool (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [rhp_pkg::IN_DATA_W-1:0]  in_tdata,  // handle_index[10:0], object_tag[42:11]
  input  logic [rhp_pkg::OP_W-1:0]       in_tuser,  // opcode[1:0]
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [rhp_pkg::OUT_DATA_W-1:0] out_tdata, // result_index[10:0], result_tag[42:11],
                                                    // ref_count[58:43], slot_freed[59]
  output logic [rhp_pkg::ST_W-1:0]       out_tuser  // status[1:0]
);
  import rhp_pkg::*;

  logic [COUNT_BITS-1:0] cnt_mem  [HANDLES];
  logic [ADDR_BITS:0]    link_mem [HANDLES];
  logic [TAG_BITS-1:0]   tag_mem  [HANDLES];

  state_t state_r, state_nxt;
  logic [ADDR_BITS:0]    init_r;
  logic [ADDR_BITS:0]    head_r, head_nxt;

  op_t                   op_r;
  logic [IDX_W-1:0]      idx_r;
  logic [TAG_BITS-1:0]   tag_r;

  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [ADDR_BITS:0]    link_rd_r;
  logic [TAG_BITS-1:0]   tag_rd_r;

  logic                  ov_r;
  status_t               o_sts_r;
  logic [IDX_W-1:0]      o_idx_r;
  logic [TAG_W-1:0]      o_tag_r;
  logic [CNT_W-1:0]      o_cnt_r;
  logic                  o_freed_r;

  logic                  in_acc, done, init_last;
  logic [IDX_W-1:0]      in_idx;
  logic [TAG_BITS-1:0]   in_tag;
  logic [ADDR_BITS-1:0]  rd_addr, slot;
  logic                  head_empty, idx_bad;

  logic                  cnt_we, link_we, tag_we;
  logic [ADDR_BITS-1:0]  cnt_wa, link_wa;
  logic [COUNT_BITS-1:0] cnt_wd;
  logic [ADDR_BITS:0]    link_wd;
  logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;

  status_t               r_sts;
  logic [IDX_W-1:0]      r_idx;
  logic [TAG_BITS-1:0]   r_tag;
  logic [COUNT_BITS-1:0] r_cnt;
  logic                  r_freed;
  logic [63:0]           tag_ext, cnt_ext;

  assign in_idx    = in_tdata[IDX_W-1:0];
  assign in_tag    = TAG_BITS'(in_tdata[IDX_W +: TAG_W]);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign done      = (state_r == S_EXEC) && (!ov_r || out_tready);
  assign init_last = (init_r == (ADDR_BITS+1)'(HANDLES - 1));

  assign rd_addr    = (op_t'(in_tuser) == OP_ASSIGN) ? head_r[ADDR_BITS-1:0]
                                                      : in_idx[ADDR_BITS-1:0];
  assign slot       = (op_r == OP_ASSIGN) ? head_r[ADDR_BITS-1:0] : idx_r[ADDR_BITS-1:0];
  assign head_empty = (head_r >= (ADDR_BITS+1)'(HANDLES));
  assign idx_bad    = (32'(idx_r) >= 32'(HANDLES)) || (cnt_rd_r == '0);
  assign cnt_inc    = cnt_rd_r + COUNT_BITS'(1);
  assign cnt_dec    = cnt_rd_r - COUNT_BITS'(1);

  always_comb begin
    cnt_we   = 1'b0;
    link_we  = 1'b0;
    tag_we   = 1'b0;
    cnt_wa   = slot;
    link_wa  = slot;
    cnt_wd   = '0;
    link_wd  = head_r;
    head_nxt = head_r;
    r_sts    = STS_OK;
    r_idx    = idx_r;
    r_tag    = tag_rd_r;
    r_cnt    = cnt_rd_r;
    r_freed  = 1'b0;
    if (state_r == S_INIT) begin
      cnt_we  = 1'b1;
      link_we = 1'b1;
      cnt_wa  = init_r[ADDR_BITS-1:0];
      link_wa = init_r[ADDR_BITS-1:0];
      link_wd = init_r + (ADDR_BITS+1)'(1);
    end else if (op_r == OP_ASSIGN) begin
      if (head_empty) begin
        r_sts = STS_EMPTY;
        r_idx = NO_HANDLE;
        r_tag = '0;
        r_cnt = '0;
      end else begin
        cnt_we   = done;
        tag_we   = done;
        cnt_wd   = COUNT_BITS'(1);
        head_nxt = link_rd_r;
        r_idx    = IDX_W'(slot);
        r_tag    = tag_r;
        r_cnt    = COUNT_BITS'(1);
      end
    end else if (idx_bad) begin
      r_sts = STS_IGNORED;
      r_tag = '0;
      r_cnt = '0;
    end else begin
      case (op_r)
        OP_ADD: begin
          if (cnt_rd_r == COUNT_MAX) begin
            r_sts = STS_SATURATED;
          end else begin
            cnt_we = done;
            cnt_wd = cnt_inc;
            r_cnt  = cnt_inc;
          end
        end
        OP_DROP: begin
          cnt_we = done;
          cnt_wd = cnt_dec;
          r_cnt  = cnt_dec;
          if (cnt_dec == '0) begin
            link_we  = done;
            head_nxt = {1'b0, slot};
            r_freed  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign tag_ext = 64'(r_tag);
  assign cnt_ext = 64'(r_cnt);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (init_last) state_nxt = S_IDLE;
      S_IDLE: if (in_acc) state_nxt = S_EXEC;
      S_EXEC: if (done) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r  <= '0;
      head_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_INIT) init_r <= init_r + (ADDR_BITS+1)'(1);
      if (done) head_r <= head_nxt;
      if (done) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= op_t'(in_tuser);
      idx_r     <= in_idx;
      tag_r     <= in_tag;
      cnt_rd_r  <= cnt_mem[rd_addr];
      link_rd_r <= link_mem[rd_addr];
      tag_rd_r  <= tag_mem[rd_addr];
    end
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (link_we) link_mem[link_wa] <= link_wd;
    if (tag_we) tag_mem[slot] <= tag_r;
  end

  always_ff @(posedge clk) begin
    if (done) begin
      o_sts_r   <= r_sts;
      o_idx_r   <= r_idx;
      o_tag_r   <= tag_ext[TAG_W-1:0];
      o_cnt_r   <= cnt_ext[CNT_W-1:0];
      o_freed_r <= r_freed;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = o_sts_r;
  assign out_tdata  = {4'b0, o_freed_r, o_cnt_r, o_tag_r, o_idx_r};

endmodule

// File: bench/tb_refcounted_handle_pool.sv
// Self-checking testbench for the reference-counted handle pool.
`timescale 1ns / 100ps

module tb_refcounted_handle_pool;
  import rhp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 16;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] cnt;
    logic             freed;
  } pool_outcome_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [ST_W-1:0]       out_tuser;

  refcounted_handle_pool dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #2 clk = ~clk;

  // pool model
  logic [IDX_W-1:0]      link_mem [HANDLES];
  logic [COUNT_BITS-1:0] count_mem[HANDLES];
  logic [TAG_BITS-1:0]   tag_mem  [HANDLES];
  logic [IDX_W-1:0]      free_head;
  logic [ADDR_BITS-1:0]  live_handles[$];
  pool_outcome_t         pending_outcomes[$];

  int send_idle  = 0;
  int recv_idle  = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  function automatic pool_outcome_t pool_op_outcome(op_t op, logic [IDX_W-1:0] idx,
                                                    logic [TAG_W-1:0] tag);
    pool_outcome_t r;
    logic [ADDR_BITS-1:0] s;
    r.status = STS_IGNORED;
    r.idx    = idx;
    r.tag    = '0;
    r.cnt    = '0;
    r.freed  = 1'b0;
    if (op == OP_ASSIGN) begin
      if (free_head >= HANDLES) begin
        r.status = STS_EMPTY;
        r.idx    = NO_HANDLE;
      end else begin
        s = free_head[ADDR_BITS-1:0];
        free_head = link_mem[s];
        tag_mem[s] = tag;
        count_mem[s] = COUNT_BITS'(1);
        live_handles.push_back(s);
        r.status = STS_OK;
        r.idx    = {1'b0, s};
        r.tag    = tag;
        r.cnt    = CNT_W'(1);
      end
      return r;
    end
    if (idx >= HANDLES) return r;
    s = idx[ADDR_BITS-1:0];
    if (count_mem[s] == 0) return r;
    r.status = STS_OK;
    case (op)
      OP_ADD: begin
        if (count_mem[s] == COUNT_MAX) r.status = STS_SATURATED;
        else count_mem[s] = count_mem[s] + 1'b1;
      end
      OP_DROP: begin
        count_mem[s] = count_mem[s] - 1'b1;
        if (count_mem[s] == 0) begin
          link_mem[s] = free_head;
          free_head = {1'b0, s};
          r.freed = 1'b1;
          foreach (live_handles[k]) begin
            if (live_handles[k] == s) begin
              live_handles.delete(k);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.tag = tag_mem[s];
    r.cnt = count_mem[s];
    return r;
  endfunction

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  // result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  pool_outcome_t want;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, expected none, actual %h / %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        compare_field("status", 32'(want.status), 32'(out_tuser));
        compare_field("result_index", 32'(want.idx), 32'(out_tdata[10:0]));
        compare_field("result_tag", want.tag, out_tdata[42:11]);
        compare_field("ref_count", 32'(want.cnt), 32'(out_tdata[58:43]));
        compare_field("slot_freed", 32'(want.freed), 32'(out_tdata[59]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(op_t op, logic [IDX_W-1:0] idx, logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {5'b0, tag, idx};
    do @(posedge clk); while (!in_tready);
    pending_outcomes.push_back(pool_op_outcome(op, idx, tag));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_live();
    return {1'b0, live_handles[$urandom_range(live_handles.size() - 1)]};
  endfunction

  task automatic test_directed();
    // free slots and missing handles are ignored
    send_item(OP_LOOKUP, 11'd0, 32'h0);
    send_item(OP_ADD, 11'd0, 32'h0);
    send_item(OP_DROP, 11'd0, 32'h0);
    send_item(OP_LOOKUP, NO_HANDLE, 32'h0);
    send_item(OP_ADD, 11'd2047, 32'hFFFF_FFFF);
    send_item(OP_DROP, 11'd1025, 32'h0);
    send_item(OP_ASSIGN, 11'd0, 32'h0000_0000);
    send_item(OP_ASSIGN, 11'd2047, 32'hFFFF_FFFF);
    send_item(OP_ASSIGN, 11'd5, 32'hA5A5_5A5A);
    send_item(OP_ADD, 11'd1, 32'h0);
    send_item(OP_LOOKUP, 11'd1, 32'h0);
    send_item(OP_DROP, 11'd1, 32'h0);
    send_item(OP_DROP, 11'd1, 32'h0);
    send_item(OP_LOOKUP, 11'd1, 32'h0);
    // freed slots come back last-in first-out
    send_item(OP_ASSIGN, 11'd0, 32'h1234_5678);
    send_item(OP_DROP, 11'd0, 32'h0);
    send_item(OP_DROP, 11'd2, 32'h0);
    send_item(OP_ASSIGN, 11'd0, 32'h8000_0001);
    send_item(OP_ASSIGN, 11'd0, 32'h7FFF_FFFE);
    send_item(OP_ASSIGN, 11'd0, 32'hDEAD_0003);
    send_item(OP_ADD, NO_HANDLE, 32'h0);
    send_item(OP_DROP, NO_HANDLE, 32'h0);
    send_item(OP_LOOKUP, 11'd1023, 32'h0);
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 28 || (r < 88 && live_handles.size() == 0))
        send_item(OP_ASSIGN, IDX_W'($urandom), $urandom);
      else if (r < 53)
        send_item(OP_ADD, pick_live(), $urandom);
      else if (r < 78)
        send_item(OP_DROP, pick_live(), $urandom);
      else if (r < 88)
        send_item(OP_LOOKUP, pick_live(), $urandom);
      else
        send_item(op_t'($urandom_range(3)), IDX_W'($urandom), $urandom);
      if (i % 150 == 149) drain_results();
    end
  endtask

  task automatic test_pool_empty();
    while (live_handles.size() < HANDLES)
      send_item(OP_ASSIGN, IDX_W'($urandom), $urandom);
    repeat (3) send_item(OP_ASSIGN, IDX_W'($urandom), $urandom);
    send_item(OP_LOOKUP, pick_live(), 32'h0);
    while (live_handles.size() > HANDLES - 8)
      send_item(OP_DROP, pick_live(), $urandom);
  endtask

  task automatic test_count_run();
    logic [IDX_W-1:0] h;
    send_item(OP_ASSIGN, 11'd0, 32'hC0FF_EE00);
    h = {1'b0, live_handles[$]};
    repeat (12) send_item(OP_ADD, h, $urandom);
    send_item(OP_LOOKUP, h, 32'h0);
    while (count_mem[h[ADDR_BITS-1:0]] != '0)
      send_item(OP_DROP, h, $urandom);
    send_item(OP_ADD, h, 32'h0);
    send_item(OP_LOOKUP, h, 32'h0);
  endtask

  initial begin
    for (int i = 0; i < HANDLES; i++) begin
      link_mem[i]  = IDX_W'(i + 1);
      count_mem[i] = '0;
      tag_mem[i]   = '0;
    end
    free_head = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 31;
    recv_idle = 68;
    test_directed();
    test_random(30);
    drain_results();

    send_idle = 68;
    recv_idle = 31;
    test_pool_empty();
    test_random(30);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    test_count_run();
    test_random(30);
    drain_results();

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
